[hw/rtl/swd_pkg.sv]
`default_nettype none

package swd_pkg;

  localparam int unsigned IN_W       = 96;
  localparam int unsigned OUT_W      = 40;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_HIGH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LOW     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY   = 3'd5;

  localparam logic [15:0] STEP_HIGH_RST  = 16'd3072;
  localparam logic [15:0] STEP_LOW_RST   = 16'd2637;
  localparam logic [15:0] MIN_RATE_RST   = 16'd480;
  localparam logic [15:0] SAMPLE_PER_RST = 16'd655;
  localparam logic [31:0] TRIGGER_RST    = 32'd62914560;
  localparam logic [15:0] REFRACTORY_RST = 16'd500;

  // leak factor, Q0.16
  localparam logic [15:0] LEAK_NUM = 16'd62259;

  typedef struct packed {
    logic [31:0] step_high_sq;
    logic [31:0] step_low_sq;
    logic [15:0] min_rotation_rate;
    logic [15:0] sample_period;
    logic [31:0] rotation_trigger_angle;
    logic [15:0] refractory_ms;
  } cfg_t;

  typedef struct packed {
    logic [30:0] x_sq;
    logic [30:0] y_sq;
    logic [30:0] z_sq;
    logic        quiet;
    logic [30:0] rot_gain;
    logic [31:0] time_ms;
  } item_t;

endpackage

`default_nettype wire

[hw/rtl/step_and_wrist_motion_detector.sv]
// Step and wrist motion detector.
// Input stream s_*: one word per sensor sample (three acceleration axes,
// gyro z rate, millisecond time). Output stream m_*: one word per sample
// with the step flag, the wrist flag and the running step total.
// Configuration: cfg_we writes cfg_data into register cfg_index; indexes
// past the last register are dropped. Write only while idle.
// Path: a word accepted on s_* is held in the input register (swd_front),
// then in the result register (swd_core), which drives m_tvalid and
// m_tdata; a stall on m_tready can hold it in the input register.
// Throughput: one word per cycle while m_tready is high; the accumulator
// leak multiply and the saturating add sit in the state update loop.
// Reset (rst, synchronous): clears both stages, the step total, the
// hysteresis state, the rotation accumulator and the last wrist time, and
// loads the default register values.
// Stall: when m_tready is low the result holds, the input stage still takes
// one more word if it is empty, then s_tready drops until the result is
// taken; s_tready follows m_tready in the same cycle.
`default_nettype none

module step_and_wrist_motion_detector import swd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // accel_x, accel_y, accel_z, rotation_rate_z, time_ms
  input  wire logic [IN_W-1:0]       s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // step_event, wrist_event, step_count, zero fill
  output logic [OUT_W-1:0]           m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_ready;

  swd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  swd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  swd_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

[hw/rtl/swd_regs.sv]
`default_nettype none

module swd_regs import swd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  logic [15:0] step_high;
  logic [15:0] step_low;
  logic [15:0] min_rotation_rate;
  logic [15:0] sample_period;
  logic [31:0] rotation_trigger_angle;
  logic [15:0] refractory_ms;
  logic [31:0] step_high_sq;
  logic [31:0] step_low_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_high              <= STEP_HIGH_RST;
      step_low               <= STEP_LOW_RST;
      min_rotation_rate      <= MIN_RATE_RST;
      sample_period          <= SAMPLE_PER_RST;
      rotation_trigger_angle <= TRIGGER_RST;
      refractory_ms          <= REFRACTORY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_HIGH:  step_high              <= cfg_data[15:0];
        REG_STEP_LOW:   step_low               <= cfg_data[15:0];
        REG_MIN_RATE:   min_rotation_rate      <= cfg_data[15:0];
        REG_SAMPLE_PER: sample_period          <= cfg_data[15:0];
        REG_TRIGGER:    rotation_trigger_angle <= cfg_data;
        REG_REFRACTORY: refractory_ms          <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // squared levels are registered and follow the raw registers in the next cycle
  always_ff @(posedge clk) begin
    step_high_sq <= 32'(step_high) * 32'(step_high);
    step_low_sq  <= 32'(step_low) * 32'(step_low);
  end

  assign cfg.step_high_sq           = step_high_sq;
  assign cfg.step_low_sq            = step_low_sq;
  assign cfg.min_rotation_rate      = min_rotation_rate;
  assign cfg.sample_period          = sample_period;
  assign cfg.rotation_trigger_angle = rotation_trigger_angle;
  assign cfg.refractory_ms          = refractory_ms;

endmodule

`default_nettype wire

[hw/rtl/swd_front.sv]
`default_nettype none

module swd_front import swd_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [IN_W-1:0] s_tdata,
  input  cfg_t                 cfg,
  output logic                 item_valid,
  input  wire logic            item_ready,
  output item_t                item
);

  logic signed [15:0] ax;
  logic signed [15:0] ay;
  logic signed [15:0] az;
  logic        [15:0] rate;
  logic        [15:0] rate_abs;
  logic signed [31:0] x_prod;
  logic signed [31:0] y_prod;
  logic signed [31:0] z_prod;
  logic        [31:0] gain_prod;
  logic               load;

  assign ax   = s_tdata[15:0];
  assign ay   = s_tdata[31:16];
  assign az   = s_tdata[47:32];
  assign rate = s_tdata[63:48];

  assign x_prod    = ax * ax;
  assign y_prod    = ay * ay;
  assign z_prod    = az * az;
  assign rate_abs  = rate[15] ? (~rate + 16'd1) : rate;
  assign gain_prod = 32'(rate_abs) * 32'(cfg.sample_period);

  assign s_tready = !item_valid || item_ready;
  assign load     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.x_sq     <= x_prod[30:0];
      item.y_sq     <= y_prod[30:0];
      item.z_sq     <= z_prod[30:0];
      item.quiet    <= rate_abs < cfg.min_rotation_rate;
      item.rot_gain <= gain_prod[30:0];
      item.time_ms  <= s_tdata[95:64];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/swd_core.sv]
`default_nettype none

module swd_core import swd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  cfg_t                  cfg,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata
);

  logic        above_level;
  logic [31:0] acc;
  logic [31:0] last_wrist_time;
  logic [31:0] step_total;

  logic        above_level_next;
  logic [31:0] acc_next;
  logic [31:0] step_total_next;

  logic        load;
  logic [31:0] mag_sq;
  logic        rising;
  logic        falling;
  logic [31:0] since_wrist;
  logic        in_window;
  logic [47:0] leak_prod;
  logic [32:0] acc_sum;
  logic [31:0] acc_sat;
  logic        fire;
  logic        step_counted;

  assign item_ready = !m_tvalid || m_tready;
  assign load       = item_valid && item_ready;

  assign mag_sq  = 32'(item.x_sq) + 32'(item.y_sq) + 32'(item.z_sq);
  assign rising  = !above_level && (mag_sq > cfg.step_high_sq);
  assign falling = above_level && (mag_sq < cfg.step_low_sq);
  assign above_level_next = rising ? 1'b1 : (falling ? 1'b0 : above_level);

  assign since_wrist = item.time_ms - last_wrist_time;
  assign in_window   = since_wrist < 32'(cfg.refractory_ms);

  assign leak_prod = 48'(acc) * 48'(LEAK_NUM);
  assign acc_sum   = 33'(acc) + 33'(item.rot_gain);
  assign acc_sat   = acc_sum[32] ? '1 : acc_sum[31:0];
  assign fire      = !in_window && !item.quiet && (acc_sat >= cfg.rotation_trigger_angle);

  always_comb begin
    if (in_window) begin
      acc_next = acc;
    end else if (item.quiet) begin
      acc_next = leak_prod[47:16];
    end else if (fire) begin
      acc_next = '0;
    end else begin
      acc_next = acc_sat;
    end
  end

  assign step_counted    = rising && !fire;
  assign step_total_next = step_total + 32'(step_counted);

  always_ff @(posedge clk) begin
    if (rst) begin
      above_level     <= 1'b0;
      acc             <= '0;
      last_wrist_time <= '0;
      step_total      <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (load) begin
        above_level <= above_level_next;
        acc         <= acc_next;
        step_total  <= step_total_next;
        if (fire) begin
          last_wrist_time <= item.time_ms;
        end
      end
      if (item_ready) begin
        m_tvalid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {6'b0, step_total_next, fire, step_counted};
    end
  end

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tdata[33:2] == step_total)
    else $error("result count differs from step total");

  a_events_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("step and wrist event on one sample");

  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    load && fire |=> acc == '0 && last_wrist_time == $past(item.time_ms))
    else $error("wrist event did not clear accumulator");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(step_total) && $stable(acc) && $stable(last_wrist_time))
    else $error("state changed without a word");
`endif

endmodule

`default_nettype wire
